FILE: src/mcta_pkg.sv
// Package for the mip chain texel address unit.
// Field widths, word structs, config struct, status and register codes, dimension helpers.
// No dependencies.
`default_nettype none

package mcta_pkg;

    localparam int MAX_DIM_LOG2 = 14;
    localparam int MAX_MIPS     = 15;

    localparam int DIM_W   = 15;   // base width / height register width
    localparam int DEPTH_W = 12;
    localparam int LVL_W   = 4;
    localparam int SLC_W   = 12;
    localparam int IDX_W   = 42;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(1) << MAX_DIM_LOG2;
    localparam logic [LVL_W-1:0] MIPS_CAP = LVL_W'(MAX_MIPS);
    localparam logic [LVL_W-1:0] LAST_MIP = LVL_W'(MAX_MIPS - 1);

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_READABLE = 3'd1,
        ST_BAD_LEVEL    = 3'd2,
        ST_BAD_SLICE    = 3'd3,
        ST_BAD_POS      = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_WIDTH  = 3'd0,
        CFG_BASE_HEIGHT = 3'd1,
        CFG_BASE_DEPTH  = 3'd2,
        CFG_MIP_LEVELS  = 3'd3,
        CFG_SLICE_COUNT = 3'd4,
        CFG_READABLE    = 3'd5
    } cfg_idx_t;

    // offset table sequencer states
    typedef enum logic [2:0] {
        OT_MUL_WH,
        OT_MUL_D,
        OT_MUL_S,
        OT_ACC,
        OT_DONE
    } ot_state_t;

    typedef struct packed {
        logic [13:0] pos_x;
        logic [13:0] pos_y;
        logic [10:0] pos_z;
        logic [3:0]  level;
        logic [10:0] slice;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] texel_index;
        status_t          status;
    } out_word_t;

    typedef struct packed {
        logic [DIM_W-1:0]   base_width;
        logic [DIM_W-1:0]   base_height;
        logic [DEPTH_W-1:0] base_depth;
        logic [LVL_W-1:0]   mip_levels;
        logic [SLC_W-1:0]   slice_count;
        logic               readable_enable;
    } cfg_t;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_CAP) ? DIM_CAP : v;
    endfunction

    // base >> level, floored at one
    function automatic logic [DIM_W-1:0] mip_dim(input logic [DIM_W-1:0] base,
                                                 input logic [LVL_W-1:0] lvl);
        logic [DIM_W-1:0] shifted;
        shifted = base >> lvl;
        return (shifted == '0) ? DIM_W'(1) : shifted;
    endfunction

endpackage

`default_nettype wire

FILE: src/mcta_offset_table.sv
// Per-level start offset table: sequencer that sums w*h*d*slices over the mip chain.
// Depends on mcta_pkg.
`default_nettype none

module mcta_offset_table
    import mcta_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rebuild,
    input  wire cfg_t             cfg,
    input  wire logic [LVL_W-1:0] rd_level,
    output logic [IDX_W-1:0]      rd_offset,
    output logic                  busy
);

    ot_state_t        state_reg, state_next;
    logic [LVL_W-1:0] mip_reg;
    logic [IDX_W-1:0] acc_reg;
    logic [IDX_W-1:0] prod_reg, prod_next;
    logic             table_we;
    logic [IDX_W-1:0] table_mem [2**LVL_W];

    logic [DIM_W-1:0] w_cur, h_cur, d_cur;

    assign w_cur = mip_dim(sat_dim(cfg.base_width), mip_reg);
    assign h_cur = mip_dim(sat_dim(cfg.base_height), mip_reg);
    assign d_cur = mip_dim(DIM_W'(cfg.base_depth), mip_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            OT_MUL_WH: state_next = OT_MUL_D;
            OT_MUL_D:  state_next = OT_MUL_S;
            OT_MUL_S:  state_next = OT_ACC;
            OT_ACC:    state_next = (mip_reg == LAST_MIP) ? OT_DONE : OT_MUL_WH;
            OT_DONE:   state_next = OT_DONE;
            default:   state_next = OT_DONE;
        endcase
        if (rebuild) begin
            state_next = OT_MUL_WH;
        end
    end

    always_comb begin
        busy     = (state_reg != OT_DONE);
        table_we = (state_reg == OT_ACC);
    end

    always_comb begin
        case (state_reg)
            OT_MUL_WH: prod_next = IDX_W'(30'(w_cur) * 30'(h_cur));
            OT_MUL_D:  prod_next = IDX_W'(prod_reg[29:0]) * IDX_W'(d_cur);
            OT_MUL_S:  prod_next = prod_reg * IDX_W'(cfg.slice_count);
            default:   prod_next = prod_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= OT_MUL_WH;
            mip_reg   <= '0;
            acc_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (rebuild) begin
                mip_reg <= '0;
                acc_reg <= '0;
            end else if (table_we) begin
                mip_reg <= mip_reg + LVL_W'(1);
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // entry m+1 holds the sum of mips 0..m; a read of level 0 returns zero
    always_ff @(posedge aclk) begin
        if (table_we && !rebuild) begin
            table_mem[mip_reg + LVL_W'(1)] <= acc_reg + prod_reg;
        end
    end

    assign rd_offset = (rd_level == '0) ? '0 : table_mem[rd_level];

endmodule

`default_nettype wire

FILE: src/mcta_addr_pipe.sv
// Five-stage address pipeline: checks, then (slice*d + z)*h + y, *w, + x + level offset.
// Depends on mcta_pkg.
`default_nettype none

module mcta_addr_pipe
    import mcta_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfg_t             cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_word_t         in_word,
    output logic [LVL_W-1:0]      tbl_level,
    input  wire logic [IDX_W-1:0] tbl_offset,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_word_t             out_word
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    // stage 1
    logic [13:0]      s1_x_reg, s1_y_reg;
    logic [10:0]      s1_z_reg, s1_slc_reg;
    logic [DIM_W-1:0] s1_w_reg, s1_h_reg;
    logic [DEPTH_W-1:0] s1_d_reg;
    status_t          s1_st_reg;
    logic [IDX_W-1:0] s1_off_reg;
    // stage 2
    logic [13:0]      s2_x_reg, s2_y_reg;
    logic [DIM_W-1:0] s2_w_reg, s2_h_reg;
    logic [22:0]      s2_t_reg;
    status_t          s2_st_reg;
    logic [IDX_W-1:0] s2_off_reg;
    // stage 3
    logic [13:0]      s3_x_reg;
    logic [DIM_W-1:0] s3_w_reg;
    logic [37:0]      s3_t_reg;
    status_t          s3_st_reg;
    logic [IDX_W-1:0] s3_off_reg;
    // stage 4
    logic [13:0]      s4_x_reg;
    logic [IDX_W-1:0] s4_t_reg;
    status_t          s4_st_reg;
    logic [IDX_W-1:0] s4_off_reg;
    // stage 5 (output)
    out_word_t        s5_word_reg;

    logic [DIM_W-1:0] w_next, h_next, d_full;
    logic [LVL_W-1:0] nmips;
    status_t          st_next;
    logic [22:0]      s2_t_next;
    logic [37:0]      s3_t_next;
    logic [IDX_W-1:0] s4_t_next;
    logic [IDX_W-1:0] idx_next;

    assign adv5     = !v5_reg || out_ready;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign tbl_level = in_word.level;

    always_comb begin
        w_next = mip_dim(sat_dim(cfg.base_width), in_word.level);
        h_next = mip_dim(sat_dim(cfg.base_height), in_word.level);
        d_full = mip_dim(DIM_W'(cfg.base_depth), in_word.level);
        nmips  = (cfg.mip_levels < MIPS_CAP) ? cfg.mip_levels : MIPS_CAP;
        // lowest code wins
        if (!cfg.readable_enable) begin
            st_next = ST_NOT_READABLE;
        end else if (in_word.level >= nmips) begin
            st_next = ST_BAD_LEVEL;
        end else if (SLC_W'(in_word.slice) >= cfg.slice_count) begin
            st_next = ST_BAD_SLICE;
        end else if (DIM_W'(in_word.pos_x) >= w_next || DIM_W'(in_word.pos_y) >= h_next
                     || DIM_W'(in_word.pos_z) >= d_full) begin
            st_next = ST_BAD_POS;
        end else begin
            st_next = ST_OK;
        end
    end

    assign s2_t_next = 23'(s1_slc_reg) * 23'(s1_d_reg) + 23'(s1_z_reg);
    assign s3_t_next = 38'(s2_t_reg) * 38'(s2_h_reg) + 38'(s2_y_reg);
    assign s4_t_next = IDX_W'(s3_t_reg) * IDX_W'(s3_w_reg);
    assign idx_next  = s4_off_reg + s4_t_reg + IDX_W'(s4_x_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_x_reg   <= in_word.pos_x;
            s1_y_reg   <= in_word.pos_y;
            s1_z_reg   <= in_word.pos_z;
            s1_slc_reg <= in_word.slice;
            s1_w_reg   <= w_next;
            s1_h_reg   <= h_next;
            s1_d_reg   <= d_full[DEPTH_W-1:0];
            s1_st_reg  <= st_next;
            s1_off_reg <= tbl_offset;
        end
        if (adv2) begin
            s2_x_reg   <= s1_x_reg;
            s2_y_reg   <= s1_y_reg;
            s2_w_reg   <= s1_w_reg;
            s2_h_reg   <= s1_h_reg;
            s2_t_reg   <= s2_t_next;
            s2_st_reg  <= s1_st_reg;
            s2_off_reg <= s1_off_reg;
        end
        if (adv3) begin
            s3_x_reg   <= s2_x_reg;
            s3_w_reg   <= s2_w_reg;
            s3_t_reg   <= s3_t_next;
            s3_st_reg  <= s2_st_reg;
            s3_off_reg <= s2_off_reg;
        end
        if (adv4) begin
            s4_x_reg   <= s3_x_reg;
            s4_t_reg   <= s4_t_next;
            s4_st_reg  <= s3_st_reg;
            s4_off_reg <= s3_off_reg;
        end
        if (adv5) begin
            s5_word_reg.texel_index <= (s4_st_reg == ST_OK) ? idx_next : '0;
            s5_word_reg.status      <= s4_st_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_word  = s5_word_reg;

endmodule

`default_nettype wire

FILE: src/mip_chain_texel_address_unit.sv
// Top level of the mip chain texel address unit: config registers, offset table, pipeline.
// Depends on mcta_pkg, mcta_offset_table, mcta_addr_pipe.
//
//  channel   ports                               direction
//  input     s_valid s_ready s_data (in_word_t)  in
//  result    m_valid m_ready m_data (out_word_t) out
//  config    cfg_valid cfg_ready cfg_index cfg_data  in
//
// One word per cycle through the five pipeline stages while no stall or table rebuild holds it.
// After reset and after each config write the level offset table is rebuilt (w*h, *d,
// *slices, accumulate per mip level), s_ready low meanwhile. Config writes are always taken.
// A stalled result holds all stages behind it; bubbles are squeezed out first.
`default_nettype none

module mip_chain_texel_address_unit
    import mcta_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t             cfg_reg;
    logic             cfg_we;
    logic             tbl_busy;
    logic             pipe_ready;
    logic [LVL_W-1:0] tbl_level;
    logic [IDX_W-1:0] tbl_offset;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_width      <= DIM_W'(1);
            cfg_reg.base_height     <= DIM_W'(1);
            cfg_reg.base_depth      <= DEPTH_W'(1);
            cfg_reg.mip_levels      <= LVL_W'(1);
            cfg_reg.slice_count     <= SLC_W'(1);
            cfg_reg.readable_enable <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BASE_WIDTH:  cfg_reg.base_width      <= cfg_data[DIM_W-1:0];
                CFG_BASE_HEIGHT: cfg_reg.base_height     <= cfg_data[DIM_W-1:0];
                CFG_BASE_DEPTH:  cfg_reg.base_depth      <= cfg_data[DEPTH_W-1:0];
                CFG_MIP_LEVELS:  cfg_reg.mip_levels      <= cfg_data[LVL_W-1:0];
                CFG_SLICE_COUNT: cfg_reg.slice_count     <= cfg_data[SLC_W-1:0];
                CFG_READABLE:    cfg_reg.readable_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mcta_offset_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rebuild   (cfg_we),
        .cfg       (cfg_reg),
        .rd_level  (tbl_level),
        .rd_offset (tbl_offset),
        .busy      (tbl_busy)
    );

    mcta_addr_pipe u_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_valid && !tbl_busy),
        .in_ready   (pipe_ready),
        .in_word    (s_data),
        .tbl_level  (tbl_level),
        .tbl_offset (tbl_offset),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_word   (m_data)
    );

    assign s_ready = pipe_ready && !tbl_busy;

endmodule

`default_nettype wire
